FILE: rtl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
// No dependencies; every other file of the block imports this package.
package iee_pkg;

   localparam int VALUE_W = 32;

   // Pending operator codes
   typedef enum logic [2:0] {
      OP_PLUS   = 3'd0,
      OP_MINUS  = 3'd1,
      OP_TIMES  = 3'd2,
      OP_DIVIDE = 3'd3,
      OP_OTHER  = 3'd4
   } op_type;

   // Input item: one character of the expression
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      div_by_zero;
   } rsp_type;

   // Front to back command: apply op to number, then emit if last
   typedef struct packed {
      op_type               op;
      logic [VALUE_W-1:0]   number;
      logic                 last;
   } cmd_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [VALUE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/iee_front.sv
// Front end: takes characters, accumulates decimal numbers, tracks the pending
// operator and issues one command per operator or final character. Uses iee_pkg.
module iee_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  iee_pkg::req_type  req_item,
   output logic              req_full,
   input  logic              cmd_full,
   output logic              cmd_push,
   output iee_pkg::cmd_type  cmd_item
);
   import iee_pkg::*;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_TIMES = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;

   op_type             pend_ff, pend_in;
   logic [VALUE_W-1:0] cur_ff, cur_in;

   logic               accept;
   logic               num_char;
   logic               apply;
   logic [3:0]         digit_val;
   logic [VALUE_W-1:0] num_acc;
   op_type             char_op;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   assign num_char  = (req_item.char_code >= CHAR_ZERO) && (req_item.char_code <= CHAR_NINE);
   assign digit_val = 4'(req_item.char_code - CHAR_ZERO);
   // x*10 + d, wrapping
   assign num_acc   = (cur_ff << 3) + (cur_ff << 1) + VALUE_W'(digit_val);
   assign apply     = (!num_char && (req_item.char_code != CHAR_SPACE)) || req_item.last_char;

   always_comb begin
      unique case (req_item.char_code)
         CHAR_PLUS:  char_op = OP_PLUS;
         CHAR_MINUS: char_op = OP_MINUS;
         CHAR_TIMES: char_op = OP_TIMES;
         CHAR_DIV:   char_op = OP_DIVIDE;
         default:    char_op = OP_OTHER;
      endcase
   end

   always_comb begin
      pend_in         = pend_ff;
      cur_in          = cur_ff;
      cmd_push        = 1'b0;
      cmd_item.op     = pend_ff;
      cmd_item.number = num_char ? num_acc : cur_ff;
      cmd_item.last   = req_item.last_char;
      if (accept) begin
         if (apply) begin
            cmd_push = 1'b1;
            cur_in   = '0;
            pend_in  = req_item.last_char ? OP_PLUS : char_op;
         end else if (num_char) begin
            cur_in = num_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= OP_PLUS;
         cur_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         cur_ff  <= cur_in;
      end
   end

endmodule

FILE: rtl/iee_queue.sv
// Short command queue between front end and back end.
// Uses iee_pkg for the command type.
module iee_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iee_pkg::cmd_type  push_item,
   output logic              full,
   input  logic              pop,
   output iee_pkg::cmd_type  head_item,
   output logic              empty
);
   import iee_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/iee_divider.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Divisor must be nonzero at start. Uses iee_pkg.
module iee_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  iee_pkg::div_req_type  div_req,
   output iee_pkg::div_rsp_type  div_rsp
);
   import iee_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIX
   } dv_state_type;

   dv_state_type       state_ff, state_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0] dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [VALUE_W-1:0] q_ff, q_in;

   logic [VALUE_W:0]   shifted;
   logic [VALUE_W:0]   diff;

   assign shifted = {rem_ff, quo_ff[VALUE_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      q_in     = q_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               rem_in   = '0;
               quo_in   = div_req.dividend[VALUE_W-1] ? ('0 - div_req.dividend)
                                                      : div_req.dividend;
               dvs_in   = div_req.divisor[VALUE_W-1] ? ('0 - div_req.divisor)
                                                     : div_req.divisor;
               neg_in   = div_req.dividend[VALUE_W-1] ^ div_req.divisor[VALUE_W-1];
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            if (!diff[VALUE_W]) begin
               rem_in = diff[VALUE_W-1:0];
               quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[VALUE_W-1:0];
               quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            q_in     = neg_ff ? ('0 - quo_ff) : quo_ff;
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

FILE: rtl/iee_back.sv
// Back end: applies queued commands to the running sum and open term, drives
// the multiplier and divider, and holds the result register. Uses iee_pkg.
module iee_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  iee_pkg::cmd_type      cmd_item,
   output logic                  cmd_pop,
   output iee_pkg::div_req_type  div_req,
   input  iee_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output iee_pkg::rsp_type      rsp_item
);
   import iee_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] sum_ff, sum_in;
   logic [VALUE_W-1:0] term_ff, term_in;
   logic               err_ff, err_in;
   logic               last_ff, last_in;
   logic [VALUE_W-1:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               take;
   logic               out_load;
   state_type          after_op;

   assign take     = rsp_pop && rsp_valid_ff;
   assign out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || take);
   assign after_op = last_ff ? ST_FIN : ST_IDLE;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      term_in        = term_ff;
      err_in         = err_ff;
      last_in        = last_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !take;
      rsp_in         = rsp_ff;
      cmd_pop        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = term_ff;
      div_req.divisor  = cmd_item.number;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               last_in  = cmd_item.last;
               state_in = cmd_item.last ? ST_FIN : ST_IDLE;
               case (cmd_item.op)
                  OP_PLUS: begin
                     sum_in  = sum_ff + term_ff;
                     term_in = cmd_item.number;
                  end
                  OP_MINUS: begin
                     sum_in  = sum_ff + term_ff;
                     term_in = '0 - cmd_item.number;
                  end
                  OP_TIMES: begin
                     prod_in  = VALUE_W'(term_ff * cmd_item.number);
                     state_in = ST_MUL;
                  end
                  OP_DIVIDE: begin
                     if (cmd_item.number == '0) begin
                        err_in  = 1'b1;
                        term_in = '0;
                     end else begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  default: ;   // unknown operator drops its number
               endcase
            end
         end
         ST_MUL: begin
            term_in  = prod_ff;
            state_in = after_op;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               term_in  = div_rsp.quotient;
               state_in = after_op;
            end
         end
         ST_FIN: begin
            if (out_load) begin
               rsp_in.value       = sum_ff + term_ff;
               rsp_in.div_by_zero = err_ff;
               rsp_valid_in       = 1'b1;
               sum_in             = '0;
               term_in            = '0;
               err_in             = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // divider is never started on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor != '0))
      else $error("divider started with zero divisor");

   // divider completion only while waiting for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider done outside wait state");

   // accumulators are back at reset values after a result is loaded
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (sum_ff == '0) && (term_ff == '0) && !err_ff && !rsp_empty)
      else $error("state not cleared after result");

   // multiply write-back state is always left in the following cycle
   a_mul_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff != ST_MUL))
      else $error("multiply state held");

endmodule

FILE: rtl/infix_expression_evaluator_top.sv
// Infix expression evaluator, top level. Instantiates iee_front, iee_queue,
// iee_back and iee_divider; uses iee_pkg.
//
// Feed an ASCII expression one character per item (req_push/req_full), with
// last_char set on the final character; one result (value, div_by_zero) comes
// out per expression on the rsp_ queue. Non-negative decimal integers joined
// by + - * / evaluate with the usual precedence, spaces are skipped, any other
// character acts as an operator that throws away the following number.
// Arithmetic wraps at 32 bits; division truncates toward zero and division by
// zero yields 0 with div_by_zero set. Digits and spaces are taken at one per
// cycle by the front end while the command queue is not full. Each operator
// or final character becomes a command that the back end executes: + - and
// unknown operators apply at once, * goes through a registered multiply and
// a write-back, / runs the bit-serial divider (start, 32 quotient bits, sign
// fix) and writes back the quotient; a final character then loads the result
// register. A queue of QUEUE_DEPTH commands lets the front end keep accepting
// while a division runs; req_full rises only when that queue fills. The result
// register frees the back end as soon as the consumer pops it.
module infix_expression_evaluator_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  iee_pkg::req_type  req_item,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output iee_pkg::rsp_type  rsp_item
);
   import iee_pkg::*;

   // front end -> command queue
   logic        cmd_push;
   cmd_type     cmd_push_item;
   logic        cmd_full;

   // command queue -> back end
   logic        cmd_pop;
   cmd_type     cmd_head;
   logic        cmd_empty;

   // back end <-> divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Number assembly and operator tracking; one command per operator or final char.
   iee_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_item (cmd_push_item)
   );

   // Decouples the one-per-cycle front end from multi-cycle execution.
   iee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_push_item),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head_item (cmd_head),
      .empty     (cmd_empty)
   );

   // Running sum / open term execution and result register.
   iee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_item  (cmd_head),
      .cmd_pop   (cmd_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   // Bit-serial signed divider for the / operator.
   iee_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
